### rtl/core/hmsd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HUB75 scan driver package
// Panel geometry, derived widths, state encodings and pixel helpers used by
// the scan driver core.
// ---------------------------------------------------------------------------
package hmsd_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 32;
    localparam int HALF_HEIGHT  = PANEL_HEIGHT / 2;

    localparam int COL_W      = $clog2(PANEL_WIDTH);
    localparam int ROW_W      = (HALF_HEIGHT > 1) ? $clog2(HALF_HEIGHT) : 1;
    localparam int HALF_DEPTH = HALF_HEIGHT * PANEL_WIDTH;
    localparam int ADDR_W     = $clog2(HALF_DEPTH);
    localparam int ROT_W      = $clog2(PANEL_WIDTH + 2);

    localparam logic [15:0] ON_TICKS_RESET = 16'd500;
    localparam logic [7:0]  CHANNEL_MASK   = 8'hff;

    typedef logic [2:0] rgb_t;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_ROTATE = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_ROTATE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_CLK_HIGH,
        PH_CLK_LOW,
        PH_LAT_HIGH,
        PH_LAT_LOW,
        PH_ENABLE,
        PH_DISABLE
    } scan_phase_t;

    // Address of a pixel inside one half of the frame store.
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(PANEL_WIDTH);
        return base + ADDR_W'(col);
    endfunction

    // A channel is lit when any bit of its 8-bit value is set.
    function automatic rgb_t colour_bits(input logic [23:0] colour);
        rgb_t bits;
        bits[0] = |(colour[23:16] & CHANNEL_MASK);
        bits[1] = |(colour[15:8] & CHANNEL_MASK);
        bits[2] = |(colour[7:0] & CHANNEL_MASK);
        return bits;
    endfunction

endpackage

### rtl/core/hmsd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module hmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/hub75_matrix_scan_driver_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HUB75 matrix scan driver core
// Frame store of one bit per colour channel and a scan sequencer that
// produces one panel pin vector per scan tick.
// ---------------------------------------------------------------------------
// Usage. A command word is taken at a rising edge with start high and busy
// low. func selects a pixel write, a left rotation of one row, or a scan
// tick. Only a scan tick gives a result word: it appears on the pin ports
// in the cycle after it is taken, marked by strobe for exactly one cycle. The
// receiver cannot stall, so the result simply passes.
// Throughput: while busy is low, pixel writes and scan ticks are taken every
// cycle, since the frame store read for a tick is issued at the accepting
// edge and its registered output feeds the data pins directly. A rotation
// walks the row through the frame store read and write ports and keeps busy
// high until the old column 0 has been written into the last column.
// Reset: after rst_n is released the frame store is cleared one entry of
// each half per cycle until every entry is cleared; busy stays high
// meanwhile. The on_ticks register resets to 500 and may be written
// through cfg_valid/cfg_data at any time, cfg_ready being always high.
// ---------------------------------------------------------------------------
module hub75_matrix_scan_driver_core
    import hmsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  pixel_row,
    input  logic [6:0]  pixel_column,
    input  logic [23:0] pixel_color,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        strobe,
    output logic [3:0]  row_select,
    output logic [2:0]  top_rgb,
    output logic [2:0]  bottom_rgb,
    output logic        shift_clock,
    output logic        latch,
    output logic        output_enable_n
);

    // Control and scan state.
    ctrl_state_t        ctrl_reg, ctrl_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [ROT_W-1:0]   rot_idx_reg, rot_idx_next;
    logic [ROW_W-1:0]   rot_row_reg, rot_row_next;
    logic               rot_bottom_reg, rot_bottom_next;
    rgb_t               first_reg, first_next;

    scan_phase_t        phase_reg, phase_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [COL_W-1:0]   scan_col_reg, scan_col_next;
    logic [15:0]        en_cnt_reg, en_cnt_next;
    logic [15:0]        en_cnt_inc;
    logic [15:0]        on_ticks_reg;

    // Result stage: the pin levels are registered here, the pixel data comes
    // straight from the registered frame store outputs.
    logic               strobe_reg;
    logic [3:0]         row_sel_reg;
    logic               clk_pin_reg, lat_pin_reg, oen_pin_reg, data_tick_reg;
    logic               clk_pin, lat_pin, oen_pin, data_tick;

    // Command decode.
    logic               accept;
    logic               acc_write, acc_rotate, acc_tick;
    logic               in_range_row, in_range_col, in_bottom;
    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;

    // Frame store ports, one memory per panel half.
    logic               top_we, bot_we;
    logic [ADDR_W-1:0]  waddr, raddr;
    rgb_t               wdata;
    rgb_t               top_rdata, bot_rdata, rot_rdata;

    assign busy      = (ctrl_reg != CTRL_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign acc_write  = accept && (func_t'(func) == FUNC_WRITE);
    assign acc_rotate = accept && (func_t'(func) == FUNC_ROTATE);
    assign acc_tick   = accept && (func_t'(func) == FUNC_TICK);

    assign in_range_row = (int'(pixel_row) < PANEL_HEIGHT);
    assign in_range_col = (int'(pixel_column) < PANEL_WIDTH);
    assign in_bottom    = (int'(pixel_row) >= HALF_HEIGHT);
    assign in_row = in_bottom ? ROW_W'(int'(pixel_row) - HALF_HEIGHT) : ROW_W'(pixel_row);
    assign in_col = COL_W'(pixel_column);

    assign rot_rdata  = rot_bottom_reg ? bot_rdata : top_rdata;
    assign en_cnt_inc = en_cnt_reg + 16'd1;

    // -----------------------------------------------------------------------
    // Control state machine: next state.
    // A rotation reads column k at index k and writes the data back one
    // column lower when it arrives in the next cycle, so the read and write of
    // one cycle never touch the same entry. Column 0 is kept aside and goes
    // to the last column at the end.
    // -----------------------------------------------------------------------
    always_comb
    begin
        ctrl_next       = ctrl_reg;
        clr_addr_next   = clr_addr_reg;
        rot_idx_next    = rot_idx_reg;
        rot_row_next    = rot_row_reg;
        rot_bottom_next = rot_bottom_reg;
        first_next      = first_reg;
        unique case (ctrl_reg)
            CTRL_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(HALF_DEPTH - 1))
                begin
                    ctrl_next = CTRL_IDLE;
                end
            end
            CTRL_IDLE:
            begin
                if (acc_rotate && in_range_row)
                begin
                    ctrl_next       = CTRL_ROTATE;
                    rot_idx_next    = '0;
                    rot_row_next    = in_row;
                    rot_bottom_next = in_bottom;
                end
            end
            CTRL_ROTATE:
            begin
                rot_idx_next = rot_idx_reg + ROT_W'(1);
                if (rot_idx_reg == ROT_W'(1))
                begin
                    first_next = rot_rdata;
                end
                if (rot_idx_reg == ROT_W'(PANEL_WIDTH + 1))
                begin
                    ctrl_next = CTRL_IDLE;
                end
            end
            default:
            begin
                ctrl_next = CTRL_IDLE;
            end
        endcase
    end

    // Control state machine: frame store port drive.
    always_comb
    begin
        top_we = 1'b0;
        bot_we = 1'b0;
        waddr  = pix_addr(in_row, in_col);
        wdata  = colour_bits(pixel_color);
        raddr  = pix_addr(scan_row_reg, scan_col_reg);
        unique case (ctrl_reg)
            CTRL_CLEAR:
            begin
                top_we = 1'b1;
                bot_we = 1'b1;
                waddr  = clr_addr_reg;
                wdata  = '0;
            end
            CTRL_IDLE:
            begin
                if (acc_write && in_range_row && in_range_col)
                begin
                    top_we = !in_bottom;
                    bot_we = in_bottom;
                end
            end
            CTRL_ROTATE:
            begin
                raddr = pix_addr(rot_row_reg, COL_W'(rot_idx_reg));
                if (rot_idx_reg == ROT_W'(PANEL_WIDTH + 1))
                begin
                    top_we = !rot_bottom_reg;
                    bot_we = rot_bottom_reg;
                    waddr  = pix_addr(rot_row_reg, COL_W'(PANEL_WIDTH - 1));
                    wdata  = first_reg;
                end
                else if (rot_idx_reg >= ROT_W'(2))
                begin
                    top_we = !rot_bottom_reg;
                    bot_we = rot_bottom_reg;
                    waddr  = pix_addr(rot_row_reg, COL_W'(rot_idx_reg - ROT_W'(2)));
                    wdata  = rot_rdata;
                end
            end
            default:
            begin
                top_we = 1'b0;
                bot_we = 1'b0;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Scan sequencer: next state, advanced once per accepted scan tick.
    // An on_ticks value of zero still gives one enabled tick, because the
    // incremented count is always at least zero.
    // -----------------------------------------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        en_cnt_next   = en_cnt_reg;
        if (acc_tick)
        begin
            unique case (phase_reg)
                PH_CLK_HIGH:
                begin
                    phase_next = PH_CLK_LOW;
                end
                PH_CLK_LOW:
                begin
                    if (scan_col_reg == COL_W'(PANEL_WIDTH - 1))
                    begin
                        scan_col_next = '0;
                        phase_next    = PH_LAT_HIGH;
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + COL_W'(1);
                        phase_next    = PH_CLK_HIGH;
                    end
                end
                PH_LAT_HIGH:
                begin
                    phase_next = PH_LAT_LOW;
                end
                PH_LAT_LOW:
                begin
                    en_cnt_next = '0;
                    phase_next  = PH_ENABLE;
                end
                PH_ENABLE:
                begin
                    en_cnt_next = en_cnt_inc;
                    if (en_cnt_inc >= on_ticks_reg)
                    begin
                        phase_next = PH_DISABLE;
                    end
                end
                PH_DISABLE:
                begin
                    if (scan_row_reg == ROW_W'(HALF_HEIGHT - 1))
                    begin
                        scan_row_next = '0;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + ROW_W'(1);
                    end
                    phase_next = PH_CLK_HIGH;
                end
                default:
                begin
                    phase_next = PH_CLK_HIGH;
                end
            endcase
        end
    end

    // Scan sequencer: pin levels of the tick taken in the current phase.
    always_comb
    begin
        clk_pin   = 1'b0;
        lat_pin   = 1'b0;
        oen_pin   = 1'b1;
        data_tick = 1'b0;
        unique case (phase_reg)
            PH_CLK_HIGH:
            begin
                clk_pin   = 1'b1;
                data_tick = 1'b1;
            end
            PH_LAT_HIGH:
            begin
                lat_pin = 1'b1;
            end
            PH_ENABLE:
            begin
                oen_pin = 1'b0;
            end
            PH_CLK_LOW, PH_LAT_LOW, PH_DISABLE:
            begin
                oen_pin = 1'b1;
            end
            default:
            begin
                oen_pin = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg       <= CTRL_CLEAR;
            clr_addr_reg   <= '0;
            rot_idx_reg    <= '0;
            phase_reg      <= PH_CLK_HIGH;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            en_cnt_reg     <= '0;
            on_ticks_reg   <= ON_TICKS_RESET;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            clr_addr_reg <= clr_addr_next;
            rot_idx_reg  <= rot_idx_next;
            phase_reg    <= phase_next;
            scan_row_reg <= scan_row_next;
            scan_col_reg <= scan_col_next;
            en_cnt_reg   <= en_cnt_next;
            strobe_reg   <= acc_tick;
            if (cfg_valid && cfg_ready)
            begin
                on_ticks_reg <= cfg_data;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        rot_row_reg    <= rot_row_next;
        rot_bottom_reg <= rot_bottom_next;
        first_reg      <= first_next;
        if (acc_tick)
        begin
            row_sel_reg   <= 4'(scan_row_reg);
            clk_pin_reg   <= clk_pin;
            lat_pin_reg   <= lat_pin;
            oen_pin_reg   <= oen_pin;
            data_tick_reg <= data_tick;
        end
    end

    hmsd_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (HALF_DEPTH)
    ) u_top_ram (
        .clk   (clk),
        .we    (top_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (top_rdata)
    );

    hmsd_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (HALF_DEPTH)
    ) u_bot_ram (
        .clk   (clk),
        .we    (bot_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (bot_rdata)
    );

    // The frame store output holds the data read at the accepting edge for
    // exactly the strobe cycle, which is when it is shown.
    assign strobe          = strobe_reg;
    assign row_select      = row_sel_reg;
    assign top_rgb         = data_tick_reg ? top_rdata : 3'b000;
    assign bottom_rgb      = data_tick_reg ? bot_rdata : 3'b000;
    assign shift_clock     = clk_pin_reg;
    assign latch           = lat_pin_reg;
    assign output_enable_n = oen_pin_reg;

    // A result word appears only for a scan tick taken on the previous edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && (func == FUNC_TICK)))
        else $error("strobe without an accepted scan tick");

    // An in-range rotate keeps the block busy while it walks the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_rotate && in_range_row) |=> busy)
        else $error("rotation did not hold busy");

    // The rotation index never passes the final write of the old column zero into the last column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == CTRL_ROTATE) |-> (rot_idx_reg <= ROT_W'(PANEL_WIDTH + 1)))
        else $error("rotation index out of range");

    // Shift clock, latch and output enable are never active together.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($countones({shift_clock, latch, !output_enable_n}) <= 1))
        else $error("conflicting panel control pins");

    // During a rotation the two frame store halves are never written together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == CTRL_ROTATE) |-> !(top_we && bot_we))
        else $error("both frame store halves written during rotation");

endmodule
